// File: src/hvsd_pkg.sv
package hvsd_pkg;

	localparam int unsigned NUM_STATES  = 8;
	localparam int unsigned NUM_SYMBOLS = 32;
	localparam int unsigned ST_W        = 3;
	localparam int unsigned ROW_W       = 3;
	localparam int unsigned COL_W       = 5;
	localparam int unsigned SYM_W       = 5;
	localparam int unsigned KIND_W      = 2;
	localparam int unsigned WGT_W       = 16;
	localparam int unsigned MET_W       = 18;
	localparam int unsigned POS_W       = 6;

	localparam logic [KIND_W-1:0] KIND_SYMBOL = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INIT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TRANS  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_EMIT   = 2'd3;

	typedef logic signed [WGT_W-1:0] weight_t;
	typedef logic signed [MET_W-1:0] metric_t;
	typedef logic [ST_W-1:0]         st_t;

	localparam weight_t W_IMP = 16'sh8000;
	localparam metric_t M_IMP = -18'sd32768;
	localparam int      FLOOR = -32767;

	// Control word broadcast from the sequencer to every cell.
	typedef struct packed {
		logic                wr_init;
		logic                wr_trans;
		logic                wr_emit;
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
		weight_t             weight;
		logic [SYM_W-1:0]    sym;
		logic                ld_pm;
		logic                ld_next;
		logic                first;
		logic                step;
		logic                shift;
		logic                norm;
		logic                clr;
	} cell_ctl_t;

	// Sum of a metric and two weights; any impossible term, or a sum below the floor,
	// gives the impossible value.
	function automatic metric_t sum3(metric_t a, weight_t b, weight_t c);
		logic signed [MET_W+1:0] s;
		s = (MET_W+2)'(a) + (MET_W+2)'(b) + (MET_W+2)'(c);
		if (a == M_IMP || b == W_IMP || c == W_IMP)
			return M_IMP;
		else if (s < FLOOR)
			return M_IMP;
		else
			return MET_W'(s);
	endfunction

endpackage

// File: src/hvsd_cell.sv
module hvsd_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hvsd_pkg::cell_ctl_t ctl,
	input  hvsd_pkg::metric_t   top,
	input  hvsd_pkg::metric_t   ring_in,
	output hvsd_pkg::metric_t   ring_out,
	output hvsd_pkg::st_t       bp
);
	import hvsd_pkg::*;

	weight_t init_q;
	weight_t trans_q [NUM_STATES];
	weight_t emit_q  [NUM_SYMBOLS];
	metric_t pm_q;
	metric_t ring_q;
	metric_t best_q;
	st_t     arg_q;
	st_t     src_q;

	weight_t                 em;
	metric_t                 cand;
	metric_t                 first_val;
	logic                    better;
	logic signed [MET_W:0]   diff;

	assign em        = emit_q[ctl.sym];
	assign cand      = sum3(ring_q, trans_q[src_q], em);
	assign first_val = sum3('0, init_q, em);
	assign better    = (cand != M_IMP) && ((best_q == M_IMP) || (cand > best_q) ||
		((cand == best_q) && (src_q < arg_q)));
	assign diff      = (MET_W+1)'(best_q) - (MET_W+1)'(top);

	assign ring_out = ring_q;
	assign bp       = arg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q <= '0;
		end else if (ctl.clr) begin
			pm_q <= '0;
		end else if (ctl.norm) begin
			if (top != M_IMP && best_q != M_IMP)
				pm_q <= (diff < FLOOR) ? M_IMP : MET_W'(diff);
			else
				pm_q <= best_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_init && ctl.row == ROW_W'(IDX))
			init_q <= ctl.weight;
		if (ctl.wr_trans && ctl.col == COL_W'(IDX))
			trans_q[ctl.row] <= ctl.weight;
		if (ctl.wr_emit && ctl.row == ROW_W'(IDX))
			emit_q[ctl.col] <= ctl.weight;

		if (ctl.ld_pm) begin
			ring_q <= pm_q;
			best_q <= M_IMP;
			arg_q  <= '0;
			src_q  <= ST_W'(IDX);
		end else if (ctl.first) begin
			best_q <= first_val;
			arg_q  <= '0;
		end else if (ctl.step) begin
			if (better) begin
				best_q <= cand;
				arg_q  <= src_q;
			end
			ring_q <= ring_in;
			src_q  <= (src_q == ST_W'(NUM_STATES - 1)) ? '0 : src_q + 1'b1;
		end else if (ctl.ld_next) begin
			ring_q <= best_q;
		end else if (ctl.shift) begin
			ring_q <= ring_in;
		end
	end

endmodule

// File: src/hmm_viterbi_state_decoder.sv
// Viterbi decoder for an eight-state, 32-symbol hidden Markov model.
// The input channel (in_valid/in_ready) carries one transaction per item: kind selects
// a symbol or a write of the initial, transition or emission table in log2 units of 1/1024.
// A symbol goes through a load; eight add-compare-select steps in which the old metrics
// rotate round the row of cells, or for the first symbol of a sequence a step from the
// initial weights; a write of the backpointer row; a scan in which the new metrics rotate
// past cell 0 to find the best one; and a renormalisation. A last symbol beyond the store
// gets only the load and the scan. On a symbol marked last, traceback writes the final
// state, then does one read of the backpointer memory and one write of the path memory
// per earlier position, after which the path leaves on the output channel in ascending
// position order (out_valid/out_ready), one path memory read ahead of each transaction.
// The block takes one item at a time: in_ready is low from a symbol's acceptance until
// its work, and any path it caused, is finished. A stalled receiver simply holds the
// block in its output state with the payload unchanged.
// Reset clears the sequence length, overflow flag and metrics; the weight tables and
// the backpointer and path memories hold nothing defined until written.
module hmm_viterbi_state_decoder #(
	parameter int unsigned MAX_LEN = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [hvsd_pkg::KIND_W-1:0]           kind,
	input  logic [hvsd_pkg::ROW_W-1:0]            row,
	input  logic [hvsd_pkg::COL_W-1:0]            col,
	input  logic signed [hvsd_pkg::WGT_W-1:0]     weight,
	input  logic [hvsd_pkg::SYM_W-1:0]            symbol,
	input  logic                                  last,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [hvsd_pkg::ST_W-1:0]             state,
	output logic [hvsd_pkg::POS_W-1:0]            position,
	output logic                                  last_res,
	output logic                                  overflow
);
	import hvsd_pkg::*;

	localparam int unsigned LW = $clog2(MAX_LEN + 1);
	localparam int unsigned AW = $clog2(MAX_LEN);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LOAD = 4'd1;
	localparam logic [3:0] S_ACS  = 4'd2;
	localparam logic [3:0] S_LDN  = 4'd3;
	localparam logic [3:0] S_SCAN = 4'd4;
	localparam logic [3:0] S_NORM = 4'd5;
	localparam logic [3:0] S_TBST = 4'd6;
	localparam logic [3:0] S_TBRD = 4'd7;
	localparam logic [3:0] S_TBWR = 4'd8;
	localparam logic [3:0] S_ORD  = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	logic [3:0]        st_q;
	logic [LW-1:0]     len_q;
	logic              ovf_q;
	logic              last_q;
	logic              acs_q;     // low when only the final pick over held metrics is wanted
	logic [SYM_W-1:0]  sym_q;
	logic [ST_W-1:0]   cnt_q;
	metric_t           top_q;
	st_t               targ_q;
	st_t               cur_q;
	logic [AW-1:0]     j_q;
	logic [AW-1:0]     oj_q;

	logic [NUM_STATES*ST_W-1:0] bp_mem [MAX_LEN];
	st_t                        path_mem [MAX_LEN];
	logic [NUM_STATES*ST_W-1:0] bp_rd_q;
	st_t                        path_rd_q;

	cell_ctl_t                  ctl;
	metric_t                    ring [NUM_STATES];
	st_t                        bp   [NUM_STATES];
	logic [NUM_STATES*ST_W-1:0] bp_row;

	logic              acc;
	logic              out_acc;
	logic              cnt_end;
	logic              path_we;
	logic [AW-1:0]     path_wa;
	st_t               path_wd;
	st_t               tb_st;

	assign acc     = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign cnt_end = (cnt_q == ST_W'(NUM_STATES - 1));
	assign tb_st   = bp_rd_q[cur_q*ST_W +: ST_W];

	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign state     = path_rd_q;
	assign position  = POS_W'(oj_q);
	assign last_res  = (LW'(oj_q) == len_q - 1'b1);
	assign overflow  = ovf_q;

	// Control word for the cell row.
	always_comb begin
		ctl          = '0;
		ctl.row      = row;
		ctl.col      = col;
		ctl.weight   = weight;
		ctl.sym      = sym_q;
		ctl.wr_init  = acc && (kind == KIND_INIT);
		ctl.wr_trans = acc && (kind == KIND_TRANS);
		ctl.wr_emit  = acc && (kind == KIND_EMIT);
		ctl.ld_pm    = (st_q == S_LOAD);
		ctl.first    = (st_q == S_ACS) && (len_q == '0);
		ctl.step     = (st_q == S_ACS) && (len_q != '0);
		ctl.ld_next  = (st_q == S_LDN);
		ctl.shift    = (st_q == S_SCAN);
		ctl.norm     = (st_q == S_NORM);
		ctl.clr      = out_acc && last_res;
	end

	for (genvar g = 0; g < NUM_STATES; g++) begin : g_cell
		hvsd_cell #(.IDX(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.top      (top_q),
			.ring_in  (ring[(g + 1) % NUM_STATES]),
			.ring_out (ring[g]),
			.bp       (bp[g])
		);
		assign bp_row[g*ST_W +: ST_W] = bp[g];
	end

	// Path memory write port: the final state first, then one state per traceback step.
	always_comb begin
		path_we = 1'b0;
		path_wa = j_q;
		path_wd = targ_q;
		case (st_q)
			S_TBST: begin
				path_we = 1'b1;
				path_wa = AW'(len_q - 1'b1);
			end
			S_TBWR: begin
				path_we = 1'b1;
				path_wa = j_q - 1'b1;
				path_wd = tb_st;
			end
			default: begin
				path_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == S_LDN)
			bp_mem[AW'(len_q)] <= bp_row;
		if (st_q == S_TBRD)
			bp_rd_q <= bp_mem[j_q];
		if (path_we)
			path_mem[path_wa] <= path_wd;
		if (st_q == S_ORD)
			path_rd_q <= path_mem[oj_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			len_q  <= '0;
			ovf_q  <= 1'b0;
			last_q <= 1'b0;
			acs_q  <= 1'b0;
			sym_q  <= '0;
			cnt_q  <= '0;
			top_q  <= M_IMP;
			targ_q <= '0;
			cur_q  <= '0;
			j_q    <= '0;
			oj_q   <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (acc && kind == KIND_SYMBOL) begin
						sym_q  <= symbol;
						last_q <= last;
						if (len_q < LW'(MAX_LEN)) begin
							acs_q <= 1'b1;
							st_q  <= S_LOAD;
						end else begin
							ovf_q <= 1'b1;
							acs_q <= 1'b0;
							if (last)
								st_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					cnt_q  <= '0;
					top_q  <= M_IMP;
					targ_q <= '0;
					st_q   <= acs_q ? S_ACS : S_SCAN;
				end
				S_ACS: begin
					cnt_q <= cnt_q + 1'b1;
					if (len_q == '0 || cnt_end)
						st_q <= S_LDN;
				end
				S_LDN: begin
					cnt_q  <= '0;
					top_q  <= M_IMP;
					targ_q <= '0;
					st_q   <= S_SCAN;
				end
				S_SCAN: begin
					// Cell 0 shows metric number cnt_q; strict compare keeps the lowest index.
					if (ring[0] != M_IMP && (top_q == M_IMP || ring[0] > top_q)) begin
						top_q  <= ring[0];
						targ_q <= cnt_q;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_end)
						st_q <= acs_q ? S_NORM : S_TBST;
				end
				S_NORM: begin
					len_q <= len_q + 1'b1;
					st_q  <= last_q ? S_TBST : S_IDLE;
				end
				S_TBST: begin
					cur_q <= targ_q;
					j_q   <= AW'(len_q - 1'b1);
					oj_q  <= '0;
					st_q  <= (len_q == LW'(1)) ? S_ORD : S_TBRD;
				end
				S_TBRD: begin
					st_q <= S_TBWR;
				end
				S_TBWR: begin
					cur_q <= tb_st;
					j_q   <= j_q - 1'b1;
					st_q  <= (j_q == AW'(1)) ? S_ORD : S_TBRD;
				end
				S_ORD: begin
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (out_acc) begin
						if (last_res) begin
							len_q <= '0;
							ovf_q <= 1'b0;
							st_q  <= S_IDLE;
						end else begin
							oj_q <= oj_q + 1'b1;
							st_q <= S_ORD;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/hvsd_chk.sv
module hvsd_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [hvsd_pkg::ST_W-1:0]    state,
	input logic [hvsd_pkg::POS_W-1:0]   position,
	input logic                         last_res,
	input logic                         overflow
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(state) && $stable(position))
		else $error("output transaction changed while stalled");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is offered");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_res |=> !out_valid)
		else $error("result offered after the final position");

	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_res |=> $stable(overflow) && !in_ready)
		else $error("overflow flag or input side moved inside a path");

endmodule

bind hmm_viterbi_state_decoder hvsd_chk u_hvsd_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.state     (state),
	.position  (position),
	.last_res  (last_res),
	.overflow  (overflow)
);

// File: tb/tb_hmm_viterbi_state_decoder.sv
module tb_hmm_viterbi_state_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import hvsd_pkg::*;

	// A weight of this value stands for zero probability. Anything that sums
	// below the floor is pulled down to it.
	localparam int IMP_W      = -32768;
	localparam int FLOOR_W    = -32767;
	localparam int SEQ_MAX    = 64;
	localparam int IDLE_LIMIT = 5000;
	// Observed symbols are drawn from the lowest few, whose emission weights are
	// all loaded before the first symbol.
	localparam int SYM_USED   = 4;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [WGT_W-1:0]  weight;
		logic [SYM_W-1:0]  symbol;
		logic              last;
	} in_item_t;

	typedef struct {
		logic [ST_W-1:0]  state;
		logic [POS_W-1:0] position;
		logic             last_res;
		logic             overflow;
	} path_entry_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [KIND_W-1:0]        kind;
	logic [ROW_W-1:0]         row;
	logic [COL_W-1:0]         col;
	logic signed [WGT_W-1:0]  weight;
	logic [SYM_W-1:0]         symbol;
	logic                     last;
	logic                     out_valid;
	logic                     out_ready;
	logic [ST_W-1:0]          state;
	logic [POS_W-1:0]         position;
	logic                     last_res;
	logic                     overflow;

	hmm_viterbi_state_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.row       (row),
		.col       (col),
		.weight    (weight),
		.symbol    (symbol),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.state     (state),
		.position  (position),
		.last_res  (last_res),
		.overflow  (overflow)
	);

	// Transactions waiting to be driven, and the path entries that the decoder
	// is predicted to emit, oldest first.
	in_item_t    pending_items[$];
	path_entry_t expected_path[$];
	int          fail_count = 0;
	int          quiet_cycles = 0;

	// Shadow of the decoder's tables and sequence state.
	int   init_tab[NUM_STATES];
	int   trans_tab[NUM_STATES*NUM_STATES];
	int   emit_tab[NUM_STATES*NUM_SYMBOLS];
	int   metric[NUM_STATES];
	int   backptr[SEQ_MAX][NUM_STATES];
	int   held_len = 0;
	bit   dropped = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int acs_sum(int a, int b, int c);
		int s;
		s = a + b + c;
		if (a == IMP_W || b == IMP_W || c == IMP_W)
			return IMP_W;
		return (s < FLOOR_W) ? IMP_W : s;
	endfunction

	// Better of two metrics where impossible loses to anything and equal values
	// keep the earlier one.
	function automatic bit beats(int cand, int incumbent);
		return cand != IMP_W && (incumbent == IMP_W || cand > incumbent);
	endfunction

	// One add-compare-select pass for the observed symbol, then renormalisation
	// by the best surviving metric.
	task automatic viterbi_advance(input int sym);
		int nxt[NUM_STATES];
		int top, best, arg, cand, em, d;
		top = IMP_W;
		for (int k = 0; k < NUM_STATES; k++) begin
			em = emit_tab[k*NUM_SYMBOLS + sym];
			if (held_len == 0) begin
				nxt[k] = acs_sum(0, init_tab[k], em);
				backptr[0][k] = 0;
			end else begin
				best = IMP_W;
				arg = 0;
				for (int l = 0; l < NUM_STATES; l++) begin
					cand = acs_sum(metric[l], trans_tab[l*NUM_STATES + k], em);
					if (beats(cand, best)) begin
						best = cand;
						arg = l;
					end
				end
				nxt[k] = best;
				backptr[held_len][k] = arg;
			end
			if (beats(nxt[k], top))
				top = nxt[k];
		end
		for (int k = 0; k < NUM_STATES; k++) begin
			if (top != IMP_W && nxt[k] != IMP_W) begin
				d = nxt[k] - top;
				metric[k] = (d < FLOOR_W) ? IMP_W : d;
			end else begin
				metric[k] = nxt[k];
			end
		end
		held_len++;
	endtask

	// Applies one accepted transaction to the shadow state; on a last symbol
	// the traced-back path is appended to the expected entries.
	task automatic decode_item(input in_item_t it);
		int path[SEQ_MAX];
		int best;
		path_entry_t e;
		case (it.kind)
			KIND_INIT: init_tab[it.row] = int'($signed(it.weight));
			KIND_TRANS: begin
				if (it.col < NUM_STATES)
					trans_tab[it.row*NUM_STATES + it.col] = int'($signed(it.weight));
			end
			KIND_EMIT: emit_tab[it.row*NUM_SYMBOLS + it.col] = int'($signed(it.weight));
			default: begin
				if (held_len < SEQ_MAX)
					viterbi_advance(int'(it.symbol));
				else
					dropped = 1;
				if (it.last) begin
					best = IMP_W;
					path[held_len-1] = 0;
					for (int k = 0; k < NUM_STATES; k++) begin
						if (beats(metric[k], best)) begin
							best = metric[k];
							path[held_len-1] = k;
						end
					end
					for (int j = held_len - 1; j > 0; j--)
						path[j-1] = backptr[j][path[j]];
					for (int j = 0; j < held_len; j++) begin
						e.state    = ST_W'(path[j]);
						e.position = POS_W'(j);
						e.last_res = (j == held_len - 1);
						e.overflow = dropped;
						expected_path.push_back(e);
					end
					foreach (metric[k])
						metric[k] = 0;
					held_len = 0;
					dropped = 0;
				end
			end
		endcase
	endtask

	// Driver. The sender runs in bursts with random gaps in between; a gap of
	// zero gives back-to-back stretches. Prediction is done at acceptance so that
	// the shadow tables follow exactly the order the block sees.
	int burst_left = 4;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		in_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind     <= KIND_SYMBOL;
			row      <= '0;
			col      <= '0;
			weight   <= '0;
			symbol   <= '0;
			last     <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				it.kind   = kind;
				it.row    = row;
				it.col    = col;
				it.weight = weight;
				it.symbol = symbol;
				it.last   = last;
				decode_item(it);
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				kind     <= it.kind;
				row      <= it.row;
				col      <= it.col;
				weight   <= it.weight;
				symbol   <= it.symbol;
				last     <= it.last;
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor. The receiver's willingness is switched at random between always ready, half
	// the time and mostly stalled.
	int ready_pct = 100;
	int ready_cycle = 0;

	always @(posedge clk or negedge arst_n) begin
		path_entry_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			ready_cycle++;
			if (ready_cycle % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: ready_pct = 100;
					1: ready_pct = 50;
					default: ready_pct = 15;
				endcase
			end
			out_ready <= ($urandom_range(0, 99) < ready_pct);
			if (out_valid && out_ready) begin
				if (expected_path.size() == 0) begin
					$error("unexpected path entry: state %0d position %0d", state, position);
					fail_count++;
				end else begin
					e = expected_path.pop_front();
					if (state !== e.state) begin
						$error("state: expected %0d, actual %0d", e.state, state);
						fail_count++;
					end
					if (position !== e.position) begin
						$error("position: expected %0d, actual %0d", e.position, position);
						fail_count++;
					end
					if (last_res !== e.last_res) begin
						$error("last_res: expected %0b, actual %0b", e.last_res, last_res);
						fail_count++;
					end
					if (overflow !== e.overflow) begin
						$error("overflow: expected %0b, actual %0b", e.overflow, overflow);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog: the run is hung if no transaction moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic logic [WGT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h0000;
			2: return 16'h8001;
			3: return 16'($urandom_range(0, 32768) * -1);
			default: return 16'($urandom_range(0, 3000) * -1);
		endcase
	endfunction

	task automatic queue_item(input logic [KIND_W-1:0] k, input int r, input int c,
			input logic [WGT_W-1:0] w, input int s, input bit l);
		in_item_t it;
		it.kind   = k;
		it.row    = ROW_W'(r);
		it.col    = COL_W'(c);
		it.weight = w;
		it.symbol = SYM_W'(s);
		it.last   = l;
		pending_items.push_back(it);
	endtask

	// A symbol transaction carries random row, column and weight, which the block
	// must ignore.
	task automatic queue_symbol(input int s, input bit l);
		queue_item(KIND_SYMBOL, $urandom_range(0, 7), $urandom_range(0, 31),
			pick_weight(), s, l);
	endtask

	task automatic queue_sequence(input int len);
		for (int i = 0; i < len; i++)
			queue_symbol($urandom_range(0, SYM_USED - 1), i == len - 1);
	endtask

	task automatic queue_table_write();
		case ($urandom_range(0, 2))
			0: queue_item(KIND_INIT, $urandom_range(0, 7), $urandom_range(0, 31),
				pick_weight(), $urandom_range(0, 31), 1'($urandom_range(0, 1)));
			1: queue_item(KIND_TRANS, $urandom_range(0, 7), $urandom_range(0, 31),
				pick_weight(), $urandom_range(0, 31), 1'($urandom_range(0, 1)));
			default: queue_item(KIND_EMIT, $urandom_range(0, 7), $urandom_range(0, 31),
				pick_weight(), $urandom_range(0, 31), 1'($urandom_range(0, 1)));
		endcase
	endtask

	initial begin
		int symbols_queued;
		int len;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every table entry that a symbol can reach is loaded before the first
		// symbol, so that no read ever touches an entry the block has not been given.
		for (int k = 0; k < NUM_STATES; k++)
			queue_item(KIND_INIT, k, 0, 16'h0000, 0, 1'b0);
		for (int r = 0; r < NUM_STATES; r++)
			for (int c = 0; c < NUM_STATES; c++)
				queue_item(KIND_TRANS, r, c, 16'h0000, 0, 1'b0);
		for (int r = 0; r < NUM_STATES; r++)
			for (int c = 0; c < SYM_USED; c++)
				queue_item(KIND_EMIT, r, c, pick_weight(), 0, 1'b0);

		// With all-zero initial and transition weights, equal metrics test the
		// rule that the lowest index wins a tie.
		queue_symbol(0, 1'b1);
		queue_symbol(3, 1'b0);
		queue_symbol(1, 1'b1);
		// A symbol that no state can emit leaves every metric impossible, so the
		// final choice falls back to state zero.
		for (int r = 0; r < NUM_STATES; r++)
			queue_item(KIND_EMIT, r, 2, 16'h8000, 0, 1'b0);
		queue_symbol(2, 1'b0);
		queue_symbol(2, 1'b1);
		for (int r = 0; r < NUM_STATES; r++)
			queue_item(KIND_EMIT, r, 2, pick_weight(), 0, 1'b0);
		// Transition writes to a destination beyond the last state are ignored.
		queue_item(KIND_TRANS, 3, 8, 16'h8000, 0, 1'b0);
		queue_item(KIND_TRANS, 7, 31, 16'h8000, 0, 1'b0);
		queue_item(KIND_TRANS, 2, 5, 16'h8001, 0, 1'b0);
		queue_item(KIND_INIT, 6, 0, 16'h8000, 0, 1'b0);
		// A sequence longer than the store: the extra symbols are dropped and the
		// last one, though dropped itself, still starts the traceback.
		queue_sequence(SEQ_MAX + 2);

		symbols_queued = 0;
		while (symbols_queued < 24) begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 6))
					queue_table_write();
			end else begin
				len = $urandom_range(1, 8);
				queue_sequence(len);
				symbols_queued += len;
			end
		end

		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_path.size() == 0);
		repeat (300) @(posedge clk);
		if (expected_path.size() != 0) begin
			$error("%0d path entries never arrived", expected_path.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
src/hvsd_pkg.sv
src/hvsd_cell.sv
src/hmm_viterbi_state_decoder.sv
src/hvsd_chk.sv
tb/tb_hmm_viterbi_state_decoder.sv
